// ----- src/address_region_registry_top_macros.svh -----
// Assertion macros for the address region registry top level.
// Included by address_region_registry_top; no other dependencies.
`ifndef ADDRESS_REGION_REGISTRY_TOP_MACROS_SVH
`define ADDRESS_REGION_REGISTRY_TOP_MACROS_SVH

// Clocked assertion with an active-low reset disable.
`define ARR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must hold whenever the block is idle.
`define ARR_ASSERT_IDLE(lbl, clk, rst_n, idle, cond, msg) \
  `ARR_ASSERT(lbl, clk, rst_n, (idle) |-> (cond), msg)

`endif

// ----- src/arr_pkg.sv -----
// Shared types and constants for the address region registry.
// Used by arr_cell, arr_ctrl and address_region_registry_top.
package arr_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned ADDR_W  = 64;

  typedef enum logic [2:0] {
    ACT_REGISTER   = 3'd0,
    ACT_LOOKUP     = 3'd1,
    ACT_UNREGISTER = 3'd2,
    ACT_RESOLVE    = 3'd3,
    ACT_SNAPSHOT   = 3'd4
  } arr_action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_NULL = 2'd3
  } arr_status_e;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
  } arr_entry_t;

  // Ring control from the sequencer: shift strobe and entry fed into the tail cell.
  typedef struct packed {
    logic       shift;
    arr_entry_t tail;
  } arr_ring_t;

endpackage

// ----- src/arr_cell.sv -----
// One cell of the region ring: holds a single table entry.
// Depends on arr_pkg for the entry type.
module arr_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  arr_pkg::arr_entry_t nb_i,
  output arr_pkg::arr_entry_t entry_o
);
  import arr_pkg::*;

  logic              valid_q, valid_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] len_q, len_d;

  always_comb begin
    valid_d = valid_q;
    base_d  = base_q;
    len_d   = len_q;
    if (shift_i) begin
      valid_d = nb_i.valid;
      base_d  = nb_i.base;
      len_d   = nb_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    len_q  <= len_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.base  = base_q;
  assign entry_o.len   = len_q;

endmodule

// ----- src/arr_ctrl.sv -----
// Request sequencer of the region registry: rotates the cell ring once per request, except null or undefined ones.
// Depends on arr_pkg; drives the ring through arr_ring_t.
module arr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                action_i,
  input  logic [arr_pkg::ADDR_W-1:0] address_i,
  input  logic [arr_pkg::ADDR_W-1:0] length_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [arr_pkg::ADDR_W-1:0] region_base_o,
  output logic [arr_pkg::ADDR_W-1:0] region_length_o,
  output logic                      last_o,
  input  arr_pkg::arr_entry_t       head_i,
  input  arr_pkg::arr_entry_t       peek_i,
  output arr_pkg::arr_ring_t        ring_o
);
  import arr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_FIT,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [2:0]        act_q, act_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] len_q, len_d;
  logic [IDX_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]  count_q, count_d;
  arr_entry_t        carry_q, carry_d;
  logic              carry_v_q, carry_v_d;
  logic              ins_q, ins_d;
  logic              hit_q, hit_d;
  logic              del_q, del_d;
  logic [ADDR_W-1:0] res_base_q, res_base_d;
  logic [ADDR_W-1:0] res_len_q, res_len_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  logic              ok1_q, ok1_d;
  logic              out_valid_q, out_valid_d;
  arr_status_e       o_status_q, o_status_d;
  logic [ADDR_W-1:0] o_base_q, o_base_d;
  logic [ADDR_W-1:0] o_len_q, o_len_d;
  logic              o_last_q, o_last_d;

  logic             en;
  logic             last_step;
  logic             full;
  logic [CNT_W-1:0] step_ext;

  assign en        = !out_valid_q || out_ready_i;
  assign last_step = (step_q == IDX_W'(ENTRIES - 1));
  assign full      = (count_q == CNT_W'(ENTRIES));
  assign step_ext  = CNT_W'(step_q);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    addr_d      = addr_q;
    len_d       = len_q;
    step_d      = step_q;
    count_d     = count_q;
    carry_d     = carry_q;
    carry_v_d   = carry_v_q;
    ins_d       = ins_q;
    hit_d       = hit_q;
    del_d       = del_q;
    res_base_d  = res_base_q;
    res_len_d   = res_len_q;
    off_d       = off_q;
    rem_d       = rem_q;
    ok1_d       = ok1_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_status_d  = o_status_q;
    o_base_d    = o_base_q;
    o_len_d     = o_len_q;
    o_last_d    = o_last_q;
    ring_o.shift = 1'b0;
    ring_o.tail  = head_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_i;
          addr_d    = address_i;
          len_d     = length_i;
          step_d    = '0;
          carry_d.valid = 1'b1;
          carry_d.base  = address_i;
          carry_d.len   = length_i;
          carry_v_d = 1'b1;
          ins_d     = 1'b0;
          hit_d     = 1'b0;
          del_d     = 1'b0;
          // Null or undefined requests skip the ring pass.
          if ((action_i == ACT_REGISTER && (address_i == '0 || length_i == '0)) ||
              (action_i == ACT_UNREGISTER && address_i == '0) ||
              (action_i > ACT_SNAPSHOT)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_PASS;
          end
        end
      end

      S_PASS: begin
        if (en) begin
          ring_o.shift = 1'b1;
          step_d = step_q + IDX_W'(1);
          case (act_q)
            ACT_REGISTER: begin
              if (carry_v_q && !ins_q && head_i.valid && head_i.base == addr_q) begin
                ring_o.tail.len = len_q;
                carry_v_d = 1'b0;
              end else if (carry_v_q && (!head_i.valid || head_i.base > carry_q.base) &&
                           (ins_q || !full)) begin
                // Insert in order, then bubble displaced entries toward the tail.
                ring_o.tail = carry_q;
                carry_d     = head_i;
                carry_v_d   = head_i.valid;
                ins_d       = 1'b1;
              end
            end
            ACT_LOOKUP: begin
              if (head_i.valid && head_i.base == addr_q) begin
                hit_d      = 1'b1;
                res_base_d = head_i.base;
                res_len_d  = head_i.len;
              end
            end
            ACT_UNREGISTER: begin
              // From the match on, pull the following entry forward to close the gap.
              if (del_q || (head_i.valid && head_i.base == addr_q)) begin
                hit_d = 1'b1;
                del_d = 1'b1;
                if (last_step) begin
                  ring_o.tail = '0;
                end else begin
                  ring_o.tail = peek_i;
                end
              end
            end
            ACT_RESOLVE: begin
              // Ascending order: the last entry not above the address wins.
              if (head_i.valid && head_i.base <= addr_q) begin
                hit_d      = 1'b1;
                res_base_d = head_i.base;
                res_len_d  = head_i.len;
                off_d      = addr_q - head_i.base;
              end
            end
            ACT_SNAPSHOT: begin
              if (step_ext < count_q) begin
                out_valid_d = 1'b1;
                o_status_d  = ST_OK;
                o_base_d    = head_i.base;
                o_len_d     = head_i.len;
                o_last_d    = ((step_ext + CNT_W'(1)) == count_q);
              end
            end
            default: begin
            end
          endcase
          if (last_step) begin
            if (act_q == ACT_RESOLVE) begin
              state_d = S_FIT;
            end else if (act_q == ACT_SNAPSHOT && count_q != '0) begin
              state_d = S_IDLE;
            end else begin
              state_d = S_FIN;
            end
          end
        end
      end

      S_FIT: begin
        ok1_d   = (off_q <= res_len_q);
        rem_d   = res_len_q - off_q;
        state_d = S_FIN;
      end

      S_FIN: begin
        if (en) begin
          out_valid_d = 1'b1;
          o_base_d    = '0;
          o_len_d     = '0;
          o_last_d    = 1'b1;
          o_status_d  = ST_MISS;
          case (act_q)
            ACT_REGISTER: begin
              if (addr_q == '0 || len_q == '0) begin
                o_status_d = ST_NULL;
              end else if (carry_v_q && !ins_q) begin
                o_status_d = ST_FULL;
              end else begin
                o_status_d = ST_OK;
                if (ins_q) begin
                  count_d = count_q + CNT_W'(1);
                end
              end
            end
            ACT_LOOKUP: begin
              if (hit_q) begin
                o_status_d = ST_OK;
                o_base_d   = res_base_q;
                o_len_d    = res_len_q;
              end
            end
            ACT_UNREGISTER: begin
              if (addr_q == '0) begin
                o_status_d = ST_NULL;
              end else if (hit_q) begin
                o_status_d = ST_OK;
                count_d    = count_q - CNT_W'(1);
              end
            end
            ACT_RESOLVE: begin
              if (hit_q && ok1_q && len_q <= rem_q) begin
                o_status_d = ST_OK;
                o_base_d   = res_base_q;
                o_len_d    = res_len_q;
              end
            end
            default: begin
            end
          endcase
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= '0;
      addr_q      <= '0;
      len_q       <= '0;
      step_q      <= '0;
      count_q     <= '0;
      carry_q     <= '0;
      carry_v_q   <= 1'b0;
      ins_q       <= 1'b0;
      hit_q       <= 1'b0;
      del_q       <= 1'b0;
      res_base_q  <= '0;
      res_len_q   <= '0;
      off_q       <= '0;
      rem_q       <= '0;
      ok1_q       <= 1'b0;
      out_valid_q <= 1'b0;
      o_status_q  <= ST_OK;
      o_base_q    <= '0;
      o_len_q     <= '0;
      o_last_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      addr_q      <= addr_d;
      len_q       <= len_d;
      step_q      <= step_d;
      count_q     <= count_d;
      carry_q     <= carry_d;
      carry_v_q   <= carry_v_d;
      ins_q       <= ins_d;
      hit_q       <= hit_d;
      del_q       <= del_d;
      res_base_q  <= res_base_d;
      res_len_q   <= res_len_d;
      off_q       <= off_d;
      rem_q       <= rem_d;
      ok1_q       <= ok1_d;
      out_valid_q <= out_valid_d;
      o_status_q  <= o_status_d;
      o_base_q    <= o_base_d;
      o_len_q     <= o_len_d;
      o_last_q    <= o_last_d;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign region_base_o   = o_base_q;
  assign region_length_o = o_len_q;
  assign last_o          = o_last_q;

endmodule

// ----- src/address_region_registry_top.sv -----
// Address region registry top level: ring of arr_cell entries and the arr_ctrl sequencer.
// Depends on arr_pkg, arr_cell, arr_ctrl and the assertion macro header.
//
// Usage: requests enter on in_valid_i/in_ready_o carrying action_i, address_i and
// length_i; results leave on out_valid_o/out_ready_i as status_o, region_base_o,
// region_length_o and last_o, with last_o set on the final result of each request.
// The table is a ring of ENTRIES cells kept in ascending base order with the used
// entries packed from cell 0. Each request rotates the whole ring once, one cell per
// cycle unless the output stalls, while the sequencer compares, inserts, removes or
// lists the entry at the head. Null or undefined requests skip the rotation. Resolve
// checks the span fit in an extra step after the pass. Snapshot posts one result per
// stored entry during the rotation itself; with a non-empty table it posts no separate
// closing result.
// A new request is taken once the previous one has finished, even if its last result
// is still waiting in the output register. A stalled receiver freezes the rotation
// until the pending result is taken. Reset empties the table at once.
`include "address_region_registry_top_macros.svh"

module address_region_registry_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 action_i,
  input  logic [arr_pkg::ADDR_W-1:0] address_i,
  input  logic [arr_pkg::ADDR_W-1:0] length_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [arr_pkg::ADDR_W-1:0] region_base_o,
  output logic [arr_pkg::ADDR_W-1:0] region_length_o,
  output logic                       last_o
);
  import arr_pkg::*;

  arr_entry_t         cell_q [ENTRIES];
  arr_ring_t          ring;
  logic [ENTRIES-1:0] cell_v;
  logic [ENTRIES-1:0] cell_inc;
  logic               packed_ok;
  logic               full_post;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    arr_entry_t nb;
    if (k == ENTRIES - 1) begin : g_tail
      assign nb = ring.tail;
    end else begin : g_mid
      assign nb = cell_q[k+1];
    end
    arr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring.shift),
      .nb_i    (nb),
      .entry_o (cell_q[k])
    );
    assign cell_v[k] = cell_q[k].valid;
  end

  arr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .address_i       (address_i),
    .length_i        (length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .region_base_o   (region_base_o),
    .region_length_o (region_length_o),
    .last_o          (last_o),
    .head_i          (cell_q[0]),
    .peek_i          (cell_q[1]),
    .ring_o          (ring)
  );

  assign cell_inc  = cell_v + {{(ENTRIES-1){1'b0}}, 1'b1};
  assign packed_ok = ((cell_v & cell_inc) == '0);
  assign full_post = out_valid_o && (status_o == ST_FULL);

  `ARR_ASSERT(a_no_shift_idle, clk_i, rst_ni, ring.shift |-> !in_ready_o, "shift while idle")
  `ARR_ASSERT_IDLE(a_packed_entries, clk_i, rst_ni, in_ready_o, packed_ok, "entries not packed")
  `ARR_ASSERT(a_full_means_full, clk_i, rst_ni, full_post |-> (&cell_v), "full with free cell")

endmodule
